>>> src/atan2_polynomial_approx_defines.svh
// Assertion macros for the atan2 approximation block.
`ifndef ATAN2_POLYNOMIAL_APPROX_DEFINES_SVH
`define ATAN2_POLYNOMIAL_APPROX_DEFINES_SVH

// same-cycle implication, sampled on clk, off during arst_n
`define ATAN2_PA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during arst_n
`define ATAN2_PA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/atan2_pa_pkg.sv
// Shared constants, types and helpers of the atan2 approximation block.
package atan2_pa_pkg;

	localparam int INPUT_BITS_DEF      = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 12;

	localparam int RATIO_BITS          = 17;
	localparam int DIV_STEPS           = RATIO_BITS;
	localparam int DIV_STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES          =
		(DIV_STEPS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

	localparam int C_BITS     = 15;
	localparam int Q_BITS     = 15;
	localparam int PHI32_BITS = 34;

	localparam logic [33:0] PI_Q32         = 34'd13493037705;
	localparam logic [16:0] ONE_Q16        = 17'd65536;
	localparam logic [15:0] QUARTER_PI_Q16 = 16'd51472;
	localparam logic [13:0] K_A            = 14'd16037;
	localparam logic [12:0] K_B            = 13'd4345;

	typedef struct packed {
		logic zero;
		logic steep;
		logic xneg;
		logic yneg;
	} octant_t;

	// round a Q.32 constant half-up to frac fraction bits
	function automatic logic [63:0] angle_const(input logic [63:0] v_q32, input int frac);
		return (v_q32 + (64'd1 << (31 - frac))) >> (32 - frac);
	endfunction

endpackage

>>> src/atan2_pa_vec_if.sv
// Input vector channel.
interface atan2_pa_vec_if #(
	parameter int INPUT_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [INPUT_BITS-1:0] vec_y;
	logic signed [INPUT_BITS-1:0] vec_x;

	modport source (output valid, output vec_y, output vec_x, input ready);
	modport sink (input valid, input vec_y, input vec_x, output ready);
endinterface

>>> src/atan2_pa_angle_if.sv
// Output angle channel.
interface atan2_pa_angle_if #(
	parameter int ANGLE_FRAC_BITS = 12
);
	localparam int ANGLE_BITS = ANGLE_FRAC_BITS + 3;

	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

>>> src/atan2_pa_div.sv
// Pipelined restoring divider forming the Q1.16 ratio lo/hi.
module atan2_pa_div #(
	parameter int INPUT_BITS = atan2_pa_pkg::INPUT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                feed_valid,
	output logic                                feed_ready,
	input  logic [INPUT_BITS-1:0]               lo,
	input  logic [INPUT_BITS-1:0]               hi,
	input  atan2_pa_pkg::octant_t               oct,
	output logic                                ratio_valid,
	input  logic                                ratio_ready,
	output logic [atan2_pa_pkg::RATIO_BITS-1:0] ratio,
	output atan2_pa_pkg::octant_t               ratio_oct
);
	import atan2_pa_pkg::*;

	localparam int NS = DIV_STAGES;

	logic                  v_s    [NS];
	logic                  v_in   [NS];
	logic                  adv    [NS];
	logic [INPUT_BITS-1:0] rem_s  [NS];
	logic [INPUT_BITS-1:0] rem_in [NS];
	logic [INPUT_BITS-1:0] rem_nx [NS];
	logic [INPUT_BITS-1:0] hi_s   [NS];
	logic [INPUT_BITS-1:0] hi_in  [NS];
	logic [RATIO_BITS-1:0] q_s    [NS];
	logic [RATIO_BITS-1:0] q_in   [NS];
	logic [RATIO_BITS-1:0] q_nx   [NS];
	octant_t               oct_s  [NS];
	octant_t               oct_in [NS];

	for (genvar s = 0; s < NS; s++) begin : g_stage
		if (s == 0) begin : g_head
			assign v_in[s]   = feed_valid;
			assign rem_in[s] = lo;
			assign hi_in[s]  = hi;
			assign q_in[s]   = '0;
			assign oct_in[s] = oct;
		end else begin : g_body
			assign v_in[s]   = v_s[s-1];
			assign rem_in[s] = rem_s[s-1];
			assign hi_in[s]  = hi_s[s-1];
			assign q_in[s]   = q_s[s-1];
			assign oct_in[s] = oct_s[s-1];
		end

		if (s == NS - 1) begin : g_tail
			assign adv[s] = !v_s[s] || ratio_ready;
		end else begin : g_mid
			assign adv[s] = !v_s[s] || adv[s+1];
		end

		// first step has no shift: it yields the integer bit (lo == hi)
		always_comb begin : p_steps
			logic [INPUT_BITS:0]   r;
			logic [RATIO_BITS-1:0] q;
			r = {1'b0, rem_in[s]};
			q = q_in[s];
			for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
				if (s * DIV_STEPS_PER_STAGE + j < DIV_STEPS) begin
					if (s * DIV_STEPS_PER_STAGE + j != 0) begin
						r = r << 1;
					end
					if (r >= {1'b0, hi_in[s]}) begin
						r = r - {1'b0, hi_in[s]};
						q = {q[RATIO_BITS-2:0], 1'b1};
					end else begin
						q = {q[RATIO_BITS-2:0], 1'b0};
					end
				end
			end
			rem_nx[s] = r[INPUT_BITS-1:0];
			q_nx[s]   = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s] <= 1'b0;
			end else if (adv[s]) begin
				v_s[s] <= v_in[s];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[s] && v_in[s]) begin
				rem_s[s] <= rem_nx[s];
				hi_s[s]  <= hi_in[s];
				q_s[s]   <= q_nx[s];
				oct_s[s] <= oct_in[s];
			end
		end
	end

	assign feed_ready  = adv[0];
	assign ratio_valid = v_s[NS-1];
	assign ratio       = q_s[NS-1];
	assign ratio_oct   = oct_s[NS-1];

endmodule

>>> src/atan2_pa_poly.sv
// Two-stage evaluation of the arctangent polynomial on the ratio.
module atan2_pa_poly (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ratio_valid,
	output logic                                ratio_ready,
	input  logic [atan2_pa_pkg::RATIO_BITS-1:0] ratio,
	input  atan2_pa_pkg::octant_t               ratio_oct,
	output logic                                phi_valid,
	input  logic                                phi_ready,
	output logic [atan2_pa_pkg::PHI32_BITS-1:0] phi32,
	output atan2_pa_pkg::octant_t               phi_oct
);
	import atan2_pa_pkg::*;

	logic                  v_s1;
	logic                  v_s2;
	logic                  adv_s1;
	logic                  adv_s2;
	logic [RATIO_BITS-1:0] r_s1;
	logic [C_BITS-1:0]     c_s1;
	logic [Q_BITS-1:0]     q_s1;
	octant_t               oct_s1;
	logic [PHI32_BITS-1:0] phi_s2;
	octant_t               oct_s2;

	logic [31:0]           c_sum;
	logic [31:0]           q_sum;
	logic [PHI32_BITS-1:0] phi_sum;

	assign adv_s2      = !v_s2 || phi_ready;
	assign adv_s1      = !v_s1 || adv_s2;
	assign ratio_ready = adv_s1;

	// c = 0.2447 + 0.0663*r, q = r*(1-r), both rounded to Q.16
	assign c_sum = {2'b00, K_A, 16'd0} + 32'(K_B) * 32'(ratio) + 32'd32768;
	assign q_sum = 32'(ratio) * 32'(ONE_Q16 - ratio) + 32'd32768;

	assign phi_sum = PHI32_BITS'(QUARTER_PI_Q16) * PHI32_BITS'(r_s1)
		+ PHI32_BITS'(q_s1) * PHI32_BITS'(c_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= ratio_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ratio_valid) begin
			r_s1   <= ratio;
			c_s1   <= c_sum[16 +: C_BITS];
			q_s1   <= q_sum[16 +: Q_BITS];
			oct_s1 <= ratio_oct;
		end
		if (adv_s2 && v_s1) begin
			phi_s2 <= phi_sum;
			oct_s2 <= oct_s1;
		end
	end

	assign phi_valid = v_s2;
	assign phi32     = phi_s2;
	assign phi_oct   = oct_s2;

endmodule

>>> src/atan2_polynomial_approx.sv
// Top level: two-argument arctangent by polynomial approximation.
//
//   channel  | role | fields                         | handshake
//   ---------+------+--------------------------------+------------
//   sample   | sink | vec_y, vec_x (INPUT_BITS, s)   | valid/ready
//   result   | src  | angle (ANGLE_FRAC_BITS+3, s)   | valid/ready
//
// One transfer per cycle while result.ready does not stall; stages: front end, divider, polynomial, fold.
// The 17 quotient bits take four per divider stage; the polynomial takes two stages.
// Every stage holds its own valid bit and advances while empty or drained,
// so bubbles close up during a stall and no transfer is lost or repeated.
// arst_n clears all valid bits; data registers are not reset.
module atan2_polynomial_approx #(
	parameter int INPUT_BITS      = atan2_pa_pkg::INPUT_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = atan2_pa_pkg::ANGLE_FRAC_BITS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	atan2_pa_vec_if.sink      sample,
	atan2_pa_angle_if.source  result
);
	import atan2_pa_pkg::*;

	localparam int AB = ANGLE_FRAC_BITS + 3;

	localparam logic signed [AB:0] PI_F =
		(AB+1)'(angle_const(64'(PI_Q32), ANGLE_FRAC_BITS));
	localparam logic signed [AB:0] HALF_PI_F =
		(AB+1)'(angle_const(64'(PI_Q32 >> 1), ANGLE_FRAC_BITS));
	localparam logic [PHI32_BITS:0] ROUND_HALF =
		(PHI32_BITS+1)'(64'd1 << (31 - ANGLE_FRAC_BITS));

	// front end
	logic                  v_s1;
	logic                  adv_s1;
	logic [INPUT_BITS-1:0] lo_s1;
	logic [INPUT_BITS-1:0] hi_s1;
	octant_t               oct_s1;
	logic [INPUT_BITS-1:0] ay;
	logic [INPUT_BITS-1:0] ax;
	octant_t               oct_nx;

	// divider to polynomial
	logic                  feed_ready;
	logic                  ratio_valid;
	logic                  ratio_ready;
	logic [RATIO_BITS-1:0] ratio;
	octant_t               ratio_oct;

	// polynomial to fold
	logic                  phi_valid;
	logic                  phi_ready;
	logic [PHI32_BITS-1:0] phi32;
	octant_t               phi_oct;

	// fold and result register
	logic                  v_s2;
	logic                  adv_s2;
	logic [AB-1:0]         angle_s2;
	logic [PHI32_BITS:0]   phi_sum;
	logic signed [AB:0]    phi_w;
	logic signed [AB:0]    a_oct;
	logic signed [AB:0]    a_quad;
	logic signed [AB:0]    a_sign;
	logic [AB-1:0]         angle_nx;

	always_comb begin
		oct_nx.yneg  = sample.vec_y[INPUT_BITS-1];
		oct_nx.xneg  = sample.vec_x[INPUT_BITS-1];
		ay           = oct_nx.yneg ? (~sample.vec_y + 1'b1) : sample.vec_y;
		ax           = oct_nx.xneg ? (~sample.vec_x + 1'b1) : sample.vec_x;
		oct_nx.steep = ay > ax;
		oct_nx.zero  = (ay == '0) && (ax == '0);
	end

	assign adv_s1       = !v_s1 || feed_ready;
	assign sample.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample.valid) begin
			lo_s1  <= oct_nx.steep ? ax : ay;
			hi_s1  <= oct_nx.steep ? ay : ax;
			oct_s1 <= oct_nx;
		end
	end

	atan2_pa_div #(
		.INPUT_BITS (INPUT_BITS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.feed_valid  (v_s1),
		.feed_ready  (feed_ready),
		.lo          (lo_s1),
		.hi          (hi_s1),
		.oct         (oct_s1),
		.ratio_valid (ratio_valid),
		.ratio_ready (ratio_ready),
		.ratio       (ratio),
		.ratio_oct   (ratio_oct)
	);

	atan2_pa_poly u_poly (
		.clk         (clk),
		.arst_n      (arst_n),
		.ratio_valid (ratio_valid),
		.ratio_ready (ratio_ready),
		.ratio       (ratio),
		.ratio_oct   (ratio_oct),
		.phi_valid   (phi_valid),
		.phi_ready   (phi_ready),
		.phi32       (phi32),
		.phi_oct     (phi_oct)
	);

	// round to the output grid, then fold into octant, quadrant and sign; a zero vector gives 0
	always_comb begin
		phi_sum  = {1'b0, phi32} + ROUND_HALF;
		phi_w    = (AB+1)'(phi_sum >> (32 - ANGLE_FRAC_BITS));
		a_oct    = phi_oct.steep ? (HALF_PI_F - phi_w) : phi_w;
		a_quad   = phi_oct.xneg ? (PI_F - a_oct) : a_oct;
		a_sign   = phi_oct.yneg ? -a_quad : a_quad;
		angle_nx = phi_oct.zero ? '0 : a_sign[AB-1:0];
	end

	assign adv_s2    = !v_s2 || result.ready;
	assign phi_ready = adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= phi_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && phi_valid) begin
			angle_s2 <= angle_nx;
		end
	end

	assign result.valid = v_s2;
	assign result.angle = angle_s2;

endmodule

>>> src/atan2_pa_chk.sv
// Port-level checker for the atan2 approximation block, with its bind.
`include "atan2_polynomial_approx_defines.svh"

module atan2_pa_chk #(
	parameter int ANGLE_FRAC_BITS = atan2_pa_pkg::ANGLE_FRAC_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              sample_valid,
	input logic                              sample_ready,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic signed [ANGLE_FRAC_BITS+2:0] angle
);
	import atan2_pa_pkg::*;

	localparam int AB = ANGLE_FRAC_BITS + 3;
	localparam logic signed [AB-1:0] PI_F =
		AB'(angle_const(64'(PI_Q32), ANGLE_FRAC_BITS));

	logic       sample_xfer;
	logic       result_xfer;
	logic [7:0] inflight_q;

	assign sample_xfer = sample_valid && sample_ready;
	assign result_xfer = result_valid && result_ready;

	// transfers taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (sample_xfer && !result_xfer) begin
			inflight_q <= inflight_q + 8'd1;
		end else if (!sample_xfer && result_xfer) begin
			inflight_q <= inflight_q - 8'd1;
		end
	end

	`ATAN2_PA_ASSERT_NEXT(a_valid_hold, result_valid && !result_ready, result_valid,
		"result valid dropped while stalled")
	`ATAN2_PA_ASSERT_NEXT(a_angle_hold, result_valid && !result_ready, $stable(angle),
		"result angle changed while stalled")
	`ATAN2_PA_ASSERT_NOW(a_angle_range, result_valid, (angle <= PI_F) && (angle >= -PI_F),
		"angle outside -pi..pi")
	`ATAN2_PA_ASSERT_NOW(a_no_phantom, result_valid, inflight_q != 8'd0,
		"result offered with no sample in flight")

endmodule

bind atan2_polynomial_approx atan2_pa_chk #(
	.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atan2_pa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.angle        (result.angle)
);
